FILE: hw/rtl/w2s_pkg.sv
// shared widths, register indexes and stage structs for the world to screen projection
// no dependencies
`default_nettype none

package w2s_pkg;

    localparam int CoordW   = 16;
    localparam int CoefW    = 16;
    localparam int ProdW    = 32;
    localparam int ClipW    = 34;
    localparam int FracNd   = 14;
    localparam int NumW     = ClipW + FracNd;
    localparam int QuoW     = 26;
    localparam int RemW     = ClipW + 1;
    localparam int NdW      = QuoW + 2;
    localparam int VpW      = 12;
    localparam int OutW     = 16;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_ROW0      = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROW1      = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_ROW2      = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_ROW3      = 8'd3;
    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X  = 8'd4;
    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y  = 8'd5;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_X    = 8'd6;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_Y    = 8'd7;

    typedef struct packed {
        logic                    valid;
        logic signed [ClipW-1:0] cx;
        logic signed [ClipW-1:0] cy;
        logic signed [ClipW-1:0] cz;
        logic signed [ClipW-1:0] cw;
    } t_clip;

    typedef struct packed {
        logic                  valid;
        logic                  wzero;
        logic signed [NdW-1:0] ndx;
        logic signed [NdW-1:0] ndy;
        logic signed [NdW-1:0] ndz;
    } t_nd;

endpackage

`default_nettype wire

FILE: hw/rtl/w2s_if.sv
// valid/ready channel interfaces: world point in, screen point out, register writes
// depends on w2s_pkg
`default_nettype none

interface w2s_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [w2s_pkg::CoordW-1:0]       world_x;
    logic signed [w2s_pkg::CoordW-1:0]       world_y;
    logic signed [w2s_pkg::CoordW-1:0]       world_z;
    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface w2s_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [w2s_pkg::OutW-1:0]         screen_x;
    logic signed [w2s_pkg::OutW-1:0]         screen_y;
    logic signed [w2s_pkg::OutW-1:0]         depth_z;
    logic                                    w_zero;
    logic                                    saturated;
    modport source (output valid, screen_x, screen_y, depth_z, w_zero, saturated,
                    input ready);
    modport sink   (input valid, screen_x, screen_y, depth_z, w_zero, saturated,
                    output ready);
endinterface

interface w2s_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [w2s_pkg::CfgIdxW-1:0]             index;
    logic [w2s_pkg::CfgDataW-1:0]            data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/world_to_screen_projection_top.sv
// path from input transfer to result: transform, divider, then viewport registers
// throughput: one point per cycle; the whole pipeline advances together and holds
// while a result waits at the output register
// reset: synchronous active low, clears all valid bits and loads the identity
// matrix with a 640x480 viewport; the register port always takes a write
`default_nettype none

module world_to_screen_projection_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    w2s_in_if.sink      i_in,
    w2s_out_if.source   o_out,
    w2s_cfg_if.sink     i_cfg
);

    logic [w2s_pkg::CfgDataW-1:0]   r_row [4];
    logic [w2s_pkg::VpW-1:0]        r_origin_x;
    logic [w2s_pkg::VpW-1:0]        r_origin_y;
    logic [w2s_pkg::VpW-1:0]        r_size_x;
    logic [w2s_pkg::VpW-1:0]        r_size_y;

    logic               en;
    w2s_pkg::t_clip     clip;
    w2s_pkg::t_nd       nd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= 64'h0000_0000_0000_1000;
            r_row[1]   <= 64'h0000_0000_1000_0000;
            r_row[2]   <= 64'h0000_1000_0000_0000;
            r_row[3]   <= 64'h1000_0000_0000_0000;
            r_origin_x <= 12'd0;
            r_origin_y <= 12'd0;
            r_size_x   <= 12'd640;
            r_size_y   <= 12'd480;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                w2s_pkg::CFG_ROW0:     r_row[0]   <= i_cfg.data;
                w2s_pkg::CFG_ROW1:     r_row[1]   <= i_cfg.data;
                w2s_pkg::CFG_ROW2:     r_row[2]   <= i_cfg.data;
                w2s_pkg::CFG_ROW3:     r_row[3]   <= i_cfg.data;
                w2s_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg.data[w2s_pkg::VpW-1:0];
                w2s_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg.data[w2s_pkg::VpW-1:0];
                w2s_pkg::CFG_SIZE_X:   r_size_x   <= i_cfg.data[w2s_pkg::VpW-1:0];
                w2s_pkg::CFG_SIZE_Y:   r_size_y   <= i_cfg.data[w2s_pkg::VpW-1:0];
                default: ;
            endcase
        end
    end

    // single stall line for the whole pipe
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    w2s_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_x     (i_in.world_x),
        .i_y     (i_in.world_y),
        .i_z     (i_in.world_z),
        .i_row   (r_row),
        .o_clip  (clip)
    );

    w2s_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_clip  (clip),
        .o_nd    (nd)
    );

    w2s_vp u_vp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_nd        (nd),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .i_size_x    (r_size_x),
        .i_size_y    (r_size_y),
        .o_valid     (o_out.valid),
        .o_screen_x  (o_out.screen_x),
        .o_screen_y  (o_out.screen_y),
        .o_depth_z   (o_out.depth_z),
        .o_w_zero    (o_out.w_zero),
        .o_saturated (o_out.saturated)
    );

    a_wzero_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.w_zero |->
            o_out.screen_x == '0 && o_out.screen_y == '0 && o_out.depth_z == '0
            && !o_out.saturated)
        else $error("zero w result carries non-zero fields");

    a_depth_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.depth_z <= 16'sd16384 && o_out.depth_z >= -16'sd16384)
        else $error("depth outside its range");

    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire

FILE: hw/rtl/w2s_xform.sv
// matrix transform: products stage then row sum stage, giving clip coordinates
// depends on w2s_pkg
`default_nettype none

module w2s_xform (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic signed [w2s_pkg::CoordW-1:0]  i_x,
    input  wire logic signed [w2s_pkg::CoordW-1:0]  i_y,
    input  wire logic signed [w2s_pkg::CoordW-1:0]  i_z,
    input  wire logic [w2s_pkg::CfgDataW-1:0]       i_row [4],
    output w2s_pkg::t_clip                          o_clip
);

    logic                               r_v1;
    logic signed [w2s_pkg::ProdW-1:0]   r_p [4][4];
    w2s_pkg::t_clip                     r_clip;
    logic signed [w2s_pkg::ProdW-1:0]   n_p [4][4];
    logic signed [w2s_pkg::ClipW-1:0]   n_sum [4];

    always_comb begin
        logic signed [w2s_pkg::CoefW-1:0] coef;
        for (int r = 0; r < 4; r++) begin
            coef = i_row[r][0 +: w2s_pkg::CoefW];
            n_p[r][0] = w2s_pkg::ProdW'(coef * i_x);
            coef = i_row[r][w2s_pkg::CoefW +: w2s_pkg::CoefW];
            n_p[r][1] = w2s_pkg::ProdW'(coef * i_y);
            coef = i_row[r][2*w2s_pkg::CoefW +: w2s_pkg::CoefW];
            n_p[r][2] = w2s_pkg::ProdW'(coef * i_z);
            // w is 1.0 in Q8.8
            coef = i_row[r][3*w2s_pkg::CoefW +: w2s_pkg::CoefW];
            n_p[r][3] = $signed({{8{coef[w2s_pkg::CoefW-1]}}, coef, 8'b0});
        end
        for (int r = 0; r < 4; r++) begin
            n_sum[r] = w2s_pkg::ClipW'(r_p[r][0]) + w2s_pkg::ClipW'(r_p[r][1])
                     + w2s_pkg::ClipW'(r_p[r][2]) + w2s_pkg::ClipW'(r_p[r][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_clip.valid <= 1'b0;
        end else if (i_en) begin
            r_v1         <= i_valid;
            r_clip.valid <= r_v1;
        end
        if (i_en) begin
            r_p       <= n_p;
            r_clip.cx <= n_sum[0];
            r_clip.cy <= n_sum[1];
            r_clip.cz <= n_sum[2];
            r_clip.cw <= n_sum[3];
        end
    end

    assign o_clip = r_clip;

endmodule

`default_nettype wire

FILE: hw/rtl/w2s_div.sv
// pipelined restoring divider: clip x, y, z over clip w, one quotient bit per stage
// depends on w2s_pkg
`default_nettype none

module w2s_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire w2s_pkg::t_clip i_clip,
    output w2s_pkg::t_nd        o_nd
);

    localparam int QW = w2s_pkg::QuoW;
    localparam int RW = w2s_pkg::RemW;
    localparam int CW = w2s_pkg::ClipW;

    // stage 0 is the set-up stage, stage k yields quotient bit QW-k
    logic                   r_v    [QW+1];
    logic                   r_wz   [QW+1];
    logic [2:0]             r_sgn  [QW+1];
    logic [2:0]             r_ovf  [QW+1];
    logic [CW-1:0]          r_den  [QW+1];
    logic [RW-1:0]          r_rem  [QW+1][3];
    logic [QW-1:0]          r_lo   [QW+1][3];
    logic [QW-1:0]          r_q    [QW+1][3];
    w2s_pkg::t_nd           r_nd;

    logic [CW-1:0]          n_den;
    logic [CW-1:0]          n_mag [3];
    logic [w2s_pkg::NumW-1:0] n_num [3];
    logic [2:0]             n_sgn;
    logic [2:0]             n_ovf;

    always_comb begin
        logic signed [CW-1:0] c [3];
        c[0] = i_clip.cx;
        c[1] = i_clip.cy;
        c[2] = i_clip.cz;
        n_den = i_clip.cw[CW-1] ? CW'(-i_clip.cw) : CW'(i_clip.cw);
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = c[k][CW-1] ? CW'(-c[k]) : CW'(c[k]);
            n_num[k] = {n_mag[k], {w2s_pkg::FracNd{1'b0}}};
            n_sgn[k] = c[k][CW-1] ^ i_clip.cw[CW-1];
            // quotient would not fit the kept bits
            n_ovf[k] = {12'b0, n_mag[k]} >= {n_den, 12'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_clip.valid;
        end
        if (i_en) begin
            r_wz[0]  <= (i_clip.cw == '0);
            r_sgn[0] <= n_sgn;
            r_ovf[0] <= n_ovf;
            r_den[0] <= n_den;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= RW'(n_num[k][w2s_pkg::NumW-1:QW]);
                r_lo[0][k]  <= n_num[k][QW-1:0];
                r_q[0][k]   <= '0;
            end
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [RW-1:0] n_rem [3];
        logic [2:0]    n_bit;

        always_comb begin
            logic [RW-1:0] shifted;
            for (int k = 0; k < 3; k++) begin
                shifted = {r_rem[s-1][k][RW-2:0], r_lo[s-1][k][QW-1]};
                n_bit[k] = shifted >= {1'b0, r_den[s-1]};
                n_rem[k] = n_bit[k] ? shifted - {1'b0, r_den[s-1]} : shifted;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
            if (i_en) begin
                r_wz[s]  <= r_wz[s-1];
                r_sgn[s] <= r_sgn[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_den[s] <= r_den[s-1];
                for (int k = 0; k < 3; k++) begin
                    r_rem[s][k] <= n_rem[k];
                    r_lo[s][k]  <= {r_lo[s-1][k][QW-2:0], 1'b0};
                    r_q[s][k]   <= {r_q[s-1][k][QW-2:0], n_bit[k]};
                end
            end
        end
    end

    logic signed [w2s_pkg::NdW-1:0] n_res [3];

    always_comb begin
        logic signed [w2s_pkg::NdW-1:0] mag;
        for (int k = 0; k < 3; k++) begin
            // overflowing quotients are pinned well past every output range
            mag = r_ovf[QW][k] ? $signed(w2s_pkg::NdW'(1) << QW)
                               : $signed(w2s_pkg::NdW'(r_q[QW][k]));
            n_res[k] = r_sgn[QW][k] ? -mag : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd.valid <= 1'b0;
        end else if (i_en) begin
            r_nd.valid <= r_v[QW];
        end
        if (i_en) begin
            r_nd.wzero <= r_wz[QW];
            r_nd.ndx   <= n_res[0];
            r_nd.ndy   <= n_res[1];
            r_nd.ndz   <= n_res[2];
        end
    end

    assign o_nd = r_nd;

endmodule

`default_nettype wire

FILE: hw/rtl/w2s_vp.sv
// viewport mapping: span multiply stage, then round, clamp and output register
// depends on w2s_pkg
`default_nettype none

module w2s_vp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire w2s_pkg::t_nd                   i_nd,
    input  wire logic [w2s_pkg::VpW-1:0]        i_origin_x,
    input  wire logic [w2s_pkg::VpW-1:0]        i_origin_y,
    input  wire logic [w2s_pkg::VpW-1:0]        i_size_x,
    input  wire logic [w2s_pkg::VpW-1:0]        i_size_y,
    output logic                                o_valid,
    output logic signed [w2s_pkg::OutW-1:0]     o_screen_x,
    output logic signed [w2s_pkg::OutW-1:0]     o_screen_y,
    output logic signed [w2s_pkg::OutW-1:0]     o_depth_z,
    output logic                                o_w_zero,
    output logic                                o_saturated
);

    localparam int TW = w2s_pkg::NdW + 1;
    localparam int SW = w2s_pkg::VpW + 1;
    localparam int PW = TW + SW;
    localparam int MW = PW + 5;
    localparam int XW = MW - 11;

    logic                               r_va;
    logic                               r_wza;
    logic signed [PW-1:0]               r_px;
    logic signed [PW-1:0]               r_py;
    logic signed [w2s_pkg::OutW-1:0]    r_dz;
    logic                               r_satz;

    logic                               r_vb;
    logic signed [w2s_pkg::OutW-1:0]    r_sx;
    logic signed [w2s_pkg::OutW-1:0]    r_sy;
    logic signed [w2s_pkg::OutW-1:0]    r_dzb;
    logic                               r_wzb;
    logic                               r_sat;

    logic signed [PW-1:0]               n_px;
    logic signed [PW-1:0]               n_py;
    logic signed [w2s_pkg::OutW-1:0]    n_dz;
    logic                               n_satz;
    logic signed [XW-1:0]               n_fx;
    logic signed [XW-1:0]               n_fy;
    logic signed [w2s_pkg::OutW-1:0]    n_sx;
    logic signed [w2s_pkg::OutW-1:0]    n_sy;
    logic                               n_satx;
    logic                               n_saty;

    always_comb begin
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [SW-1:0] spx;
        logic signed [SW-1:0] spy;
        tx  = TW'(i_nd.ndx) + TW'(16384);
        ty  = TW'(i_nd.ndy) + TW'(16384);
        spx = $signed({1'b0, i_size_x}) - $signed({1'b0, i_origin_x});
        spy = $signed({1'b0, i_origin_y}) - $signed({1'b0, i_size_y});
        n_px = PW'(tx) * PW'(spx);
        n_py = PW'(ty) * PW'(spy);
        n_satz = 1'b0;
        if (i_nd.ndz > w2s_pkg::NdW'(16384)) begin
            n_dz = 16'sd16384;
            n_satz = 1'b1;
        end else if (i_nd.ndz < -w2s_pkg::NdW'(16384)) begin
            n_dz = -16'sd16384;
            n_satz = 1'b1;
        end else begin
            n_dz = i_nd.ndz[w2s_pkg::OutW-1:0];
        end
    end

    always_comb begin
        logic signed [MW-1:0] numx;
        logic signed [MW-1:0] numy;
        // base in Q.15, span product in Q.14 shifted up by 4, plus half for round half up
        numx = $signed(MW'({i_origin_x, 15'b0})) + (MW'(r_px) <<< 4) + MW'(1024);
        numy = $signed(MW'({i_size_y, 15'b0})) + (MW'(r_py) <<< 4) + MW'(1024);
        n_fx = numx[MW-1:11];
        n_fy = numy[MW-1:11];
        n_satx = 1'b1;
        n_saty = 1'b1;
        if (n_fx > XW'(32767))       n_sx = 16'sh7fff;
        else if (n_fx < -XW'(32768)) n_sx = -16'sh8000;
        else begin
            n_sx = n_fx[w2s_pkg::OutW-1:0];
            n_satx = 1'b0;
        end
        if (n_fy > XW'(32767))       n_sy = 16'sh7fff;
        else if (n_fy < -XW'(32768)) n_sy = -16'sh8000;
        else begin
            n_sy = n_fy[w2s_pkg::OutW-1:0];
            n_saty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_nd.valid;
            r_vb <= r_va;
        end
        if (i_en) begin
            r_wza  <= i_nd.wzero;
            r_px   <= n_px;
            r_py   <= n_py;
            r_dz   <= n_dz;
            r_satz <= n_satz;
            r_wzb  <= r_wza;
            r_sx   <= r_wza ? '0 : n_sx;
            r_sy   <= r_wza ? '0 : n_sy;
            r_dzb  <= r_wza ? '0 : r_dz;
            r_sat  <= !r_wza && (n_satx || n_saty || r_satz);
        end
    end

    assign o_valid     = r_vb;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_depth_z   = r_dzb;
    assign o_w_zero    = r_wzb;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

FILE: dv/w2s_checker.sv
// checker for the world to screen projection: watches the point, result and register channels
// predicts each result from its own copy of the matrix and viewport; depends on w2s_pkg, w2s_if
`timescale 1ns / 1ps

module w2s_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    w2s_in_if.sink      i_in,
    w2s_out_if.sink     i_out,
    w2s_cfg_if.sink     i_cfg,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_wzero_seen,
    output int          o_sat_seen
);

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] depth_z;
        logic               w_zero;
        logic               saturated;
    } t_screen_point;

    logic [63:0]   mat_row [4];
    logic [11:0]   org_x, org_y, sz_x, sz_y;
    t_screen_point expected_points [$];

    function automatic longint floor_div2048(longint n);
        longint q;
        q = n / 2048;
        if ((n % 2048) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint map_viewport(longint nd, longint base, longint far_end);
        return floor_div2048(base * 32768 + (nd + 16384) * (far_end - base) * 16 + 1024);
    endfunction

    function automatic longint clamp_val(longint v, longint lo, longint hi, ref logic sat);
        if (v < lo) begin sat = 1'b1; return lo; end
        if (v > hi) begin sat = 1'b1; return hi; end
        return v;
    endfunction

    function automatic t_screen_point project_point(logic signed [15:0] wx,
                                                    logic signed [15:0] wy,
                                                    logic signed [15:0] wz);
        longint pt [4];
        longint clip [4];
        longint ndx, ndy, ndz;
        logic sat;
        t_screen_point r;
        pt[0] = wx; pt[1] = wy; pt[2] = wz; pt[3] = 256;
        for (int row = 0; row < 4; row++) begin
            clip[row] = 0;
            for (int col = 0; col < 4; col++)
                clip[row] += longint'($signed(mat_row[row][16*col +: 16])) * pt[col];
        end
        r = '0;
        sat = 1'b0;
        if (clip[3] == 0) begin
            r.w_zero = 1'b1;
            return r;
        end
        // clip fits in 34 bits, so the shift by 14 stays within 64
        ndx = (clip[0] * 16384) / clip[3];
        ndy = (clip[1] * 16384) / clip[3];
        ndz = (clip[2] * 16384) / clip[3];
        r.screen_x = 16'(clamp_val(map_viewport(ndx, org_x, sz_x), -32768, 32767, sat));
        r.screen_y = 16'(clamp_val(map_viewport(ndy, sz_y, org_y), -32768, 32767, sat));
        r.depth_z  = 16'(clamp_val(ndz, -16384, 16384, sat));
        r.saturated = sat;
        return r;
    endfunction

    assign o_pending = expected_points.size();

    always @(posedge i_clk) begin
        t_screen_point exp_pt;
        if (!i_rst_n) begin
            mat_row[0] <= 64'h0000_0000_0000_1000;
            mat_row[1] <= 64'h0000_0000_1000_0000;
            mat_row[2] <= 64'h0000_1000_0000_0000;
            mat_row[3] <= 64'h1000_0000_0000_0000;
            org_x <= '0;
            org_y <= '0;
            sz_x  <= 12'd640;
            sz_y  <= 12'd480;
            expected_points.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_wzero_seen <= 0;
            o_sat_seen <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    w2s_pkg::CFG_ROW0:     mat_row[0] <= i_cfg.data;
                    w2s_pkg::CFG_ROW1:     mat_row[1] <= i_cfg.data;
                    w2s_pkg::CFG_ROW2:     mat_row[2] <= i_cfg.data;
                    w2s_pkg::CFG_ROW3:     mat_row[3] <= i_cfg.data;
                    w2s_pkg::CFG_ORIGIN_X: org_x <= i_cfg.data[11:0];
                    w2s_pkg::CFG_ORIGIN_Y: org_y <= i_cfg.data[11:0];
                    w2s_pkg::CFG_SIZE_X:   sz_x  <= i_cfg.data[11:0];
                    w2s_pkg::CFG_SIZE_Y:   sz_y  <= i_cfg.data[11:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_points.push_back(project_point(i_in.world_x, i_in.world_y,
                                                        i_in.world_z));
            if (i_out.valid && i_out.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (i_out.w_zero) o_wzero_seen <= o_wzero_seen + 1;
                if (i_out.saturated) o_sat_seen <= o_sat_seen + 1;
                if (expected_points.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (i_out.screen_x !== exp_pt.screen_x ||
                        i_out.screen_y !== exp_pt.screen_y ||
                        i_out.depth_z !== exp_pt.depth_z ||
                        i_out.w_zero !== exp_pt.w_zero ||
                        i_out.saturated !== exp_pt.saturated)
                        o_fail_count <= o_fail_count + 1;
                    if (i_out.screen_x !== exp_pt.screen_x)
                        $error("screen_x expected %0d got %0d", exp_pt.screen_x, i_out.screen_x);
                    if (i_out.screen_y !== exp_pt.screen_y)
                        $error("screen_y expected %0d got %0d", exp_pt.screen_y, i_out.screen_y);
                    if (i_out.depth_z !== exp_pt.depth_z)
                        $error("depth_z expected %0d got %0d", exp_pt.depth_z, i_out.depth_z);
                    if (i_out.w_zero !== exp_pt.w_zero)
                        $error("w_zero expected %0b got %0b", exp_pt.w_zero, i_out.w_zero);
                    if (i_out.saturated !== exp_pt.saturated)
                        $error("saturated expected %0b got %0b", exp_pt.saturated,
                               i_out.saturated);
                end
            end
        end
    end

endmodule

FILE: dv/testbench.sv
// top of the world to screen projection testbench: clock, reset, stimulus and verdict
// depends on w2s_pkg, w2s_if, w2s_checker and the block itself
`timescale 1ns / 1ps

module testbench;

    localparam int LatencyCycles = 32;
    // index past the register list, must be ignored
    localparam logic [w2s_pkg::CfgIdxW-1:0] CfgIdxUnused = 8'd200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, results_seen, wzero_seen, sat_seen;
    int   hold_off_cycles;
    int   points_sent;
    bit   allow_stall;

    w2s_in_if  in_ch ();
    w2s_out_if out_ch ();
    w2s_cfg_if cfg_ch ();

    world_to_screen_projection_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    w2s_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch.sink),
        .i_out          (out_ch.sink),
        .i_cfg          (cfg_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_wzero_seen   (wzero_seen),
        .o_sat_seen     (sat_seen)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // result side: random stalls, plus one long hold-off counted in its own process
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end else if (allow_stall && gap_len() > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_point(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
        int gap;
        gap = gap_len();
        if (allow_stall)
            repeat (gap) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        in_ch.valid   <= 1'b1;
        in_ch.world_x <= wx;
        in_ch.world_y <= wy;
        in_ch.world_z <= wz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        points_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LatencyCycles + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [w2s_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coef(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 8192)) - 16'd4096;
            1: return 16'($urandom());
            default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    function automatic logic [63:0] rand_row(int mode);
        return {rand_coef(mode), rand_coef(mode), rand_coef(mode), rand_coef(mode)};
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 1024)) - 16'd512;
            1: return 16'($urandom());
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [15:0] wx;
        for (int k = 0; k < count; k++) begin
            wx = rand_coord();
            send_point(wx, rand_coord(), rand_coord());
        end
    endtask

    initial begin : limit
        #20ms;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [63:0] w_row;
        in_ch.valid = 1'b0;
        in_ch.world_x = '0;
        in_ch.world_y = '0;
        in_ch.world_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        hold_off_cycles = 0;
        points_sent = 0;
        allow_stall = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity matrix at reset, field extremes and the origin
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h0100, 16'h0100, 16'h0100);
        send_point(16'hff00, 16'hff00, 16'hff00);
        send_point(16'h7fff, 16'h8000, 16'h7fff);
        send_point(16'h8000, 16'h7fff, 16'h8000);
        send_point(16'hffff, 16'h0001, 16'h5555);
        drain();
        // w row only picks up z, so z = 0 gives a zero w
        write_reg(w2s_pkg::CFG_ROW3, 64'h0000_1000_0000_0000);
        send_point(16'h1234, 16'h4321, 16'h0000);
        send_point(16'h0100, 16'h0100, 16'h0100);
        send_point(16'h0100, 16'h0100, 16'hff00);
        send_point(16'h7fff, 16'h8000, 16'h0001);
        send_point(16'h8000, 16'h7fff, 16'hffff);
        drain();
        // backwards viewport and extreme registers
        write_reg(w2s_pkg::CFG_ORIGIN_X, 64'hfff);
        write_reg(w2s_pkg::CFG_SIZE_X, 64'h000);
        write_reg(w2s_pkg::CFG_ORIGIN_Y, 64'hfff);
        write_reg(w2s_pkg::CFG_SIZE_Y, 64'h000);
        write_reg(w2s_pkg::CFG_ROW0, 64'h7fff_8000_7fff_8000);
        write_reg(w2s_pkg::CFG_ROW1, 64'h8000_7fff_8000_7fff);
        write_reg(w2s_pkg::CFG_ROW2, 64'hffff_ffff_ffff_ffff);
        write_reg(CfgIdxUnused, 64'hdead_beef_0000_0001);
        send_point(16'h0100, 16'hff00, 16'h0200);
        send_point(16'h7fff, 16'h7fff, 16'h0001);
        send_point(16'h8000, 16'h8000, 16'h7fff);
        send_point(16'h0000, 16'h0000, 16'h8000);
        drain();

        allow_stall = 1'b1;
        for (int phase = 0; phase < 10; phase++) begin
            for (int r = 0; r < 4; r++) begin
                w_row = rand_row(phase % 3);
                // keep w mostly positive with a healthy w coefficient
                if (r == 3 && phase % 3 == 0) w_row[63:48] = 16'($urandom_range(256, 8192));
                write_reg(w2s_pkg::CfgIdxW'(r), w_row);
            end
            write_reg(w2s_pkg::CFG_ORIGIN_X,
                      (phase == 1) ? 64'hfff : 64'($urandom_range(0, 4095)));
            write_reg(w2s_pkg::CFG_ORIGIN_Y, 64'($urandom_range(0, 4095)));
            write_reg(w2s_pkg::CFG_SIZE_X, (phase == 1) ? 64'h0 : 64'($urandom()));
            write_reg(w2s_pkg::CFG_SIZE_Y, 64'($urandom_range(0, 4095)));
            if (phase == 4) hold_off_cycles = 150;
            random_phase(phase == 9 ? 20 : 110);
            if (phase % 4 == 3) begin
                // w row picks up x only, with a zero w coefficient: x = 0 points give zero w
                drain();
                write_reg(w2s_pkg::CFG_ROW3, 64'h0000_0000_0000_1000);
                for (int k = 0; k < 10; k++)
                    send_point(k[0] ? 16'h0000 : rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        $display("sent %0d points, %0d results checked (%0d zero w, %0d clamped)",
                 points_sent, results_seen, wzero_seen, sat_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
